[rtl/flcf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flcf_pkg - shared types and constants of the path and cycle finder
// Item codes, the command and result groups between the unit and its search
// engine, and the engine's sequencer states.
// ----------------------------------------------------------------------------
package flcf_pkg;

    // field widths fixed by the item format
    localparam int VERTEX_W = 5;
    localparam int LEN_W    = 5;
    localparam int MODE_W   = 2;

    // default graph size and the reset value of the vertex count register
    localparam int                DEFAULT_VERTICES = 20;
    localparam logic [VERTEX_W-1:0] COUNT_RESET    = 5'd20;

    // witness limits
    localparam int MAX_RESULTS = 20;
    localparam int MIN_CYCLE   = 3;
    localparam int STACK_DEPTH = 21;
    localparam int STACK_W     = $clog2(STACK_DEPTH);

    // item kinds carried in tuser
    typedef enum logic [MODE_W-1:0] {
        MODE_SET   = 2'd0,
        MODE_CLEAR = 2'd1,
        MODE_PATH  = 2'd2,
        MODE_CYCLE = 2'd3
    } mode_t;

    // one input item as seen by the engine, with the active vertex count
    typedef struct packed {
        mode_t               mode;
        logic [VERTEX_W-1:0] vertex_a;
        logic [VERTEX_W-1:0] vertex_b;
        logic [LEN_W-1:0]    length;
        logic [VERTEX_W-1:0] count;
    } cmd_t;

    // one result item
    typedef struct packed {
        logic                found;
        logic [VERTEX_W-1:0] vertex;
        logic [VERTEX_W-1:0] position;
        logic                last;
    } res_t;

    // search sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_POP,
        ST_OUT_RD,
        ST_OUT,
        ST_MISS
    } state_t;

endpackage

[rtl/flcf_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flcf_engine - adjacency store and backtracking search sequencer
// Holds the undirected adjacency matrix, applies edge items, and searches depth
// first over an explicit stack, one neighbour candidate per cycle between pops.
// ----------------------------------------------------------------------------
module flcf_engine #(
    parameter int VERTICES = flcf_pkg::DEFAULT_VERTICES
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  flcf_pkg::cmd_t cmd,
    output logic          res_valid,
    input  logic          res_ready,
    output flcf_pkg::res_t res
);

    // only vertices below 32 can ever be named by an item
    localparam int ROWS = (VERTICES < 32) ? VERTICES : 32;
    localparam int VW   = $clog2(ROWS);
    localparam int SW   = flcf_pkg::STACK_W;
    localparam int XW   = flcf_pkg::VERTEX_W;

    flcf_pkg::state_t state_reg, state_next;

    logic [ROWS-1:0] adj_reg [ROWS];
    logic [ROWS-1:0] visited_reg, visited_next;
    logic [SW-1:0]   d_reg, d_next;
    logic [XW-1:0]   cur_reg, cur_next;
    logic [XW-1:0]   w_reg, w_next;
    logic [XW-1:0]   start_reg, start_next;
    logic [XW-1:0]   target_reg, target_next;
    logic [XW-1:0]   n_reg, n_next;
    logic [SW-1:0]   tgt_reg, tgt_next;
    logic [XW-1:0]   k_reg, k_next;
    logic            cyc_reg, cyc_next;

    // stack memories, one write and one registered read port each
    logic [XW-1:0] stack_vertex_mem [flcf_pkg::STACK_DEPTH];
    logic [XW-1:0] stack_next_mem   [flcf_pkg::STACK_DEPTH];
    logic [XW-1:0] stack_vertex_rd_reg;
    logic [XW-1:0] stack_next_rd_reg;
    logic          sv_we;
    logic [SW-1:0] sv_waddr;
    logic [XW-1:0] sv_wdata;
    logic          nn_we;
    logic [SW-1:0] nn_waddr;
    logic [XW-1:0] nn_wdata;
    logic [SW-1:0] rd_addr;

    logic          edge_we;
    logic [ROWS-1:0] adj_row;
    logic          cand_ok;
    logic          hit;
    logic          at_target;

    assign adj_row   = adj_reg[cur_reg[VW-1:0]];
    assign at_target = (d_reg == tgt_reg);

    // terminal check: cycle closes back to start, path ends on target
    assign hit = cyc_reg ? adj_row[start_reg[VW-1:0]] : (cur_reg == target_reg);

    // shared neighbour test on the current candidate
    always_comb
    begin
        cand_ok = adj_row[w_reg[VW-1:0]] && !visited_reg[w_reg[VW-1:0]];
        if (!cyc_reg && (w_reg == target_reg) && ((d_reg + 1'b1) != tgt_reg))
        begin
            cand_ok = 1'b0;
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= flcf_pkg::ST_IDLE;
            visited_reg <= '0;
            d_reg       <= '0;
            cur_reg     <= '0;
            w_reg       <= '0;
            start_reg   <= '0;
            target_reg  <= '0;
            n_reg       <= '0;
            tgt_reg     <= '0;
            k_reg       <= '0;
            cyc_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            visited_reg <= visited_next;
            d_reg       <= d_next;
            cur_reg     <= cur_next;
            w_reg       <= w_next;
            start_reg   <= start_next;
            target_reg  <= target_next;
            n_reg       <= n_next;
            tgt_reg     <= tgt_next;
            k_reg       <= k_next;
            cyc_reg     <= cyc_next;
        end
    end

    // adjacency matrix, both directions updated by one edge item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ROWS; i++)
            begin
                adj_reg[i] <= '0;
            end
        end
        else if (edge_we)
        begin
            for (int i = 0; i < ROWS; i++)
            begin
                if (cmd.vertex_a[VW-1:0] == VW'(i))
                begin
                    adj_reg[i][cmd.vertex_b[VW-1:0]] <= (cmd.mode == flcf_pkg::MODE_SET);
                end
                if (cmd.vertex_b[VW-1:0] == VW'(i))
                begin
                    adj_reg[i][cmd.vertex_a[VW-1:0]] <= (cmd.mode == flcf_pkg::MODE_SET);
                end
            end
        end
    end

    // stack memories
    always_ff @(posedge clk)
    begin
        stack_vertex_rd_reg <= stack_vertex_mem[rd_addr];
        stack_next_rd_reg   <= stack_next_mem[rd_addr];
        if (sv_we)
        begin
            stack_vertex_mem[sv_waddr] <= sv_wdata;
        end
        if (nn_we)
        begin
            stack_next_mem[nn_waddr] <= nn_wdata;
        end
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        visited_next = visited_reg;
        d_next       = d_reg;
        cur_next     = cur_reg;
        w_next       = w_reg;
        start_next   = start_reg;
        target_next  = target_reg;
        n_next       = n_reg;
        tgt_next     = tgt_reg;
        k_next       = k_reg;
        cyc_next     = cyc_reg;
        sv_we        = 1'b0;
        sv_waddr     = '0;
        sv_wdata     = '0;
        nn_we        = 1'b0;
        nn_waddr     = d_reg;
        nn_wdata     = w_reg + 1'b1;
        rd_addr      = k_reg[SW-1:0];
        edge_we      = 1'b0;
        cmd_ready    = 1'b0;
        res_valid    = 1'b0;
        res          = '0;

        unique case (state_reg)
            flcf_pkg::ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    target_next = cmd.vertex_b;
                    n_next      = cmd.count;
                    d_next      = '0;
                    k_next      = '0;
                    unique case (cmd.mode)
                        flcf_pkg::MODE_SET, flcf_pkg::MODE_CLEAR:
                        begin
                            edge_we = ({1'b0, cmd.vertex_a} < 6'(ROWS)) &&
                                      ({1'b0, cmd.vertex_b} < 6'(ROWS)) &&
                                      (cmd.vertex_a != cmd.vertex_b);
                        end
                        flcf_pkg::MODE_PATH:
                        begin
                            cyc_next = 1'b0;
                            tgt_next = cmd.length[SW-1:0];
                            if ((cmd.vertex_a >= cmd.count) ||
                                (cmd.length > XW'(flcf_pkg::MAX_RESULTS - 1)))
                            begin
                                state_next = flcf_pkg::ST_MISS;
                            end
                            else
                            begin
                                visited_next = {{(ROWS-1){1'b0}}, 1'b1} << cmd.vertex_a[VW-1:0];
                                cur_next     = cmd.vertex_a;
                                w_next       = '0;
                                start_next   = cmd.vertex_a;
                                sv_we        = 1'b1;
                                sv_wdata     = cmd.vertex_a;
                                state_next   = flcf_pkg::ST_SEARCH;
                            end
                        end
                        flcf_pkg::MODE_CYCLE:
                        begin
                            cyc_next = 1'b1;
                            tgt_next = SW'(cmd.length - 1'b1);
                            if ((cmd.length < XW'(flcf_pkg::MIN_CYCLE)) ||
                                (cmd.length > XW'(flcf_pkg::MAX_RESULTS)) ||
                                (cmd.count == '0))
                            begin
                                state_next = flcf_pkg::ST_MISS;
                            end
                            else
                            begin
                                visited_next = {{(ROWS-1){1'b0}}, 1'b1};
                                cur_next     = '0;
                                w_next       = '0;
                                start_next   = '0;
                                sv_we        = 1'b1;
                                sv_wdata     = '0;
                                state_next   = flcf_pkg::ST_SEARCH;
                            end
                        end
                        default:
                        begin
                            state_next = flcf_pkg::ST_IDLE;
                        end
                    endcase
                end
            end

            flcf_pkg::ST_SEARCH:
            begin
                priority if (at_target && hit)
                begin
                    k_next     = '0;
                    state_next = flcf_pkg::ST_OUT_RD;
                end
                else if (!at_target && (w_reg < n_reg) && cand_ok)
                begin
                    // descend into the candidate
                    nn_we        = 1'b1;
                    visited_next = visited_reg | ({{(ROWS-1){1'b0}}, 1'b1} << w_reg[VW-1:0]);
                    sv_we        = 1'b1;
                    sv_waddr     = d_reg + 1'b1;
                    sv_wdata     = w_reg;
                    d_next       = d_reg + 1'b1;
                    cur_next     = w_reg;
                    w_next       = cyc_reg ? start_reg : '0;
                end
                else if (!at_target && (w_reg < n_reg))
                begin
                    w_next = w_reg + 1'b1;
                end
                else if (d_reg != '0)
                begin
                    // backtrack one level, reload the parent from the stack
                    visited_next = visited_reg &
                                   ~({{(ROWS-1){1'b0}}, 1'b1} << cur_reg[VW-1:0]);
                    d_next     = d_reg - 1'b1;
                    rd_addr    = d_reg - 1'b1;
                    state_next = flcf_pkg::ST_POP;
                end
                else if (cyc_reg && ((start_reg + 1'b1) < n_reg))
                begin
                    // next start vertex for the cycle search
                    visited_next = {{(ROWS-1){1'b0}}, 1'b1} << (start_reg[VW-1:0] + 1'b1);
                    start_next   = start_reg + 1'b1;
                    cur_next     = start_reg + 1'b1;
                    w_next       = start_reg + 1'b1;
                    sv_we        = 1'b1;
                    sv_wdata     = start_reg + 1'b1;
                end
                else
                begin
                    state_next = flcf_pkg::ST_MISS;
                end
            end

            flcf_pkg::ST_POP:
            begin
                cur_next   = stack_vertex_rd_reg;
                w_next     = stack_next_rd_reg;
                state_next = flcf_pkg::ST_SEARCH;
            end

            flcf_pkg::ST_OUT_RD:
            begin
                state_next = flcf_pkg::ST_OUT;
            end

            flcf_pkg::ST_OUT:
            begin
                res_valid    = 1'b1;
                res.found    = 1'b1;
                res.vertex   = stack_vertex_rd_reg;
                res.position = k_reg;
                res.last     = (k_reg[SW-1:0] == tgt_reg);
                if (res_ready)
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = res.last ? flcf_pkg::ST_IDLE : flcf_pkg::ST_OUT_RD;
                end
            end

            flcf_pkg::ST_MISS:
            begin
                res_valid = 1'b1;
                res.last  = 1'b1;
                if (res_ready)
                begin
                    state_next = flcf_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = flcf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/fixed_length_path_cycle_finder_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_length_path_cycle_finder_unit - fixed-length path and cycle finder
// Edge items maintain an undirected graph; query items search it depth first
// and return the first witness found, one vertex per item.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready      tuser mode, tdata a, b, length
//  m_axis    out  m_axis_tvalid/tready      tuser found, tdata vertex,
//                                           position, tlast last
//  cfg       in   cfg_valid/cfg_ready       vertex_count
//
//  An edge item is applied on acceptance. A query tests each neighbour
//  candidate in the shared scan step, reads the stack on every backtrack and
//  for every result item; the total follows the size of the search tree.
//  Reset clears the adjacency matrix at once, with no clearing pass.
//  s_axis_tready is low from a query's acceptance until its last result item
//  has entered the output register; m_axis stalls hold the engine in place.
//
module fixed_length_path_cycle_finder_unit #(
    parameter int VERTICES = flcf_pkg::DEFAULT_VERTICES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // vertex_a, vertex_b, length
    input  logic [1:0]  s_axis_tuser,   // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // vertex, position
    output logic [0:0]  m_axis_tuser,   // found
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data
);

    localparam int ROWS = (VERTICES < 32) ? VERTICES : 32;

    logic [flcf_pkg::VERTEX_W-1:0] vertex_count_reg;
    logic [flcf_pkg::VERTEX_W-1:0] active_count;
    flcf_pkg::cmd_t cmd;
    flcf_pkg::res_t res;
    flcf_pkg::res_t out_reg;
    logic           out_valid_reg;
    logic           res_valid;
    logic           res_ready;

    // vertex count register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= flcf_pkg::COUNT_RESET;
        end
        else if (cfg_valid)
        begin
            vertex_count_reg <= cfg_data;
        end
    end

    // searches see at most the vertices that exist
    assign active_count = ({1'b0, vertex_count_reg} < 6'(ROWS)) ?
                          vertex_count_reg : flcf_pkg::VERTEX_W'(ROWS);

    // unpack the input item
    always_comb
    begin
        cmd.mode     = flcf_pkg::mode_t'(s_axis_tuser);
        cmd.vertex_a = s_axis_tdata[4:0];
        cmd.vertex_b = s_axis_tdata[9:5];
        cmd.length   = s_axis_tdata[14:10];
        cmd.count    = active_count;
    end

    flcf_engine #(
        .VERTICES (VERTICES)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (s_axis_tvalid),
        .cmd_ready (s_axis_tready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output register
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_reg.position, out_reg.vertex};
    assign m_axis_tuser  = out_reg.found;
    assign m_axis_tlast  = out_reg.last;

endmodule

[rtl/flcf_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flcf_checker - port-level checks on the path and cycle finder
// Watches the stream ports of the unit over time; attached by bind.
// ----------------------------------------------------------------------------
module flcf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [15:0] s_axis_tdata,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // a stalled result item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result item changed");

    // a not-found item is a lone, zeroed final item
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast && (m_axis_tdata == 16'd0))
        else $error("not-found item malformed");

    // a query keeps the input closed while it runs
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser[1] |=> !s_axis_tready)
        else $error("input reopened straight after a query");

    // an edge item leaves the input open
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && !s_axis_tuser[1] |=> s_axis_tready)
        else $error("edge item blocked the input");

    // more witness items follow a non-final one, so the input stays closed
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input open in the middle of a witness");

endmodule

bind fixed_length_path_cycle_finder_unit flcf_checker u_flcf_checker (.*);

[test/fixed_length_path_cycle_finder_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_length_path_cycle_finder_unit_test - path and cycle finder testbench
// Edge items build a graph in the unit and in a local depth-first predictor.
// Each query item queues the predicted witness, and every result item is
// checked against it. Directed cases come first, then random traffic under
// three stall profiles. Queries whose search tree is too big are not sent.
// ----------------------------------------------------------------------------
module fixed_length_path_cycle_finder_unit_test;

    localparam int NODES         = flcf_pkg::DEFAULT_VERTICES;
    localparam int SEARCH_BUDGET = 2000;
    localparam int STALL_LIMIT   = 100000;
    localparam int REPORT_LIMIT  = 10;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_ITEMS  = 160;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;     // vertex_a, vertex_b, length
    logic [1:0]  s_axis_tuser = flcf_pkg::MODE_SET;   // mode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;          // vertex, position
    logic [0:0]  m_axis_tuser;          // found
    logic        m_axis_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [4:0]  cfg_data = '0;

    // predictor state: graph, register copy and search scratch
    logic [NODES-1:0] graph [NODES];
    logic [4:0]       vertex_limit;
    logic [NODES-1:0] on_route;
    logic [4:0]       route [flcf_pkg::STACK_DEPTH];
    logic [4:0]       next_try [flcf_pkg::STACK_DEPTH];
    flcf_pkg::res_t   pending_results [$];

    flcf_pkg::res_t seen_result;
    flcf_pkg::res_t wanted_result;
    int   mismatch_count = 0;
    int   quiet_cycles = 0;
    int   send_gap = 24;
    int   recv_gap = 84;
    bit   sent_flag;

    fixed_length_path_cycle_finder_unit #(
        .VERTICES(NODES)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    // random back-pressure on the result side
    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= recv_gap);
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen_result.found    = m_axis_tuser[0];
            seen_result.vertex   = m_axis_tdata[4:0];
            seen_result.position = m_axis_tdata[9:5];
            seen_result.last     = m_axis_tlast;
            if (pending_results.size() == 0)
            begin
                if (mismatch_count < REPORT_LIMIT)
                    $display("%0t: unexpected result found=%0b vertex=%0d position=%0d last=%0b",
                             $time, seen_result.found, seen_result.vertex,
                             seen_result.position, seen_result.last);
                mismatch_count++;
            end
            else
            begin
                wanted_result = pending_results.pop_front();
                if (seen_result.found !== wanted_result.found ||
                    seen_result.vertex !== wanted_result.vertex ||
                    seen_result.position !== wanted_result.position ||
                    seen_result.last !== wanted_result.last)
                begin
                    if (mismatch_count < REPORT_LIMIT)
                    begin
                        $display("%0t: expected found=%0b vertex=%0d position=%0d last=%0b",
                                 $time, wanted_result.found, wanted_result.vertex,
                                 wanted_result.position, wanted_result.last);
                        $display("%0t: got      found=%0b vertex=%0d position=%0d last=%0b",
                                 $time, seen_result.found, seen_result.vertex,
                                 seen_result.position, seen_result.last);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("fixed_length_path_cycle_finder_unit: mismatch");
            $finish;
        end
    end

    // depth-first path search; witness count, 0 when none, -1 over budget
    function automatic int search_path(input int a, input int b, input int len,
                                       input int n);
        int d;
        int w;
        int cur;
        int work;
        work = 0;
        if (a >= n || len + 1 > flcf_pkg::MAX_RESULTS)
            return 0;
        on_route = '0;
        on_route[a] = 1'b1;
        route[0] = 5'(a);
        next_try[0] = '0;
        d = 0;
        while (1)
        begin
            if (work > SEARCH_BUDGET)
                return -1;
            cur = route[d];
            if (d == len)
            begin
                if (cur == b)
                    return len + 1;
                w = n;
            end
            else
            begin
                w = next_try[d];
                // the target may only be entered on the final edge
                while (w < n && !(graph[cur][w] && !on_route[w] &&
                                  !(w == b && len - d != 1)))
                begin
                    w++;
                    work++;
                end
                work++;
            end
            if (w < n)
            begin
                next_try[d] = 5'(w + 1);
                on_route[w] = 1'b1;
                d++;
                route[d] = 5'(w);
                next_try[d] = '0;
            end
            else
            begin
                if (d == 0)
                    return 0;
                on_route[cur] = 1'b0;
                d--;
                work += 2;
            end
        end
    endfunction

    // cycle search from each start, using only vertices at or above it
    function automatic int search_cycle(input int len, input int n);
        int d;
        int w;
        int cur;
        int s;
        int work;
        work = 0;
        if (len < flcf_pkg::MIN_CYCLE || len > flcf_pkg::MAX_RESULTS)
            return 0;
        for (s = 0; s < n; s++)
        begin
            d = 0;
            on_route = '0;
            on_route[s] = 1'b1;
            route[0] = 5'(s);
            next_try[0] = 5'(s);
            while (1)
            begin
                if (work > SEARCH_BUDGET)
                    return -1;
                cur = route[d];
                if (d == len - 1)
                begin
                    if (graph[cur][s])
                        return len;
                    w = n;
                end
                else
                begin
                    w = next_try[d];
                    while (w < n && !(graph[cur][w] && !on_route[w]))
                    begin
                        w++;
                        work++;
                    end
                    work++;
                end
                if (w < n)
                begin
                    next_try[d] = 5'(w + 1);
                    on_route[w] = 1'b1;
                    d++;
                    route[d] = 5'(w);
                    next_try[d] = 5'(s);
                end
                else
                begin
                    if (d == 0)
                        break;
                    on_route[cur] = 1'b0;
                    d--;
                    work += 2;
                end
            end
        end
        return 0;
    endfunction

    // predict one item, queue its results and send it; costly queries are dropped
    task automatic issue_item(input flcf_pkg::mode_t mode, input logic [4:0] a,
                              input logic [4:0] b, input logic [4:0] len,
                              output bit sent);
        int             n;
        int             m;
        int             k;
        flcf_pkg::res_t r;
        sent = 1'b0;
        n = (vertex_limit < NODES) ? int'(vertex_limit) : NODES;
        m = 0;
        if (mode == flcf_pkg::MODE_PATH)
            m = search_path(a, b, len, n);
        else if (mode == flcf_pkg::MODE_CYCLE)
            m = search_cycle(len, n);
        if (m < 0)
            return;

        if (mode == flcf_pkg::MODE_SET || mode == flcf_pkg::MODE_CLEAR)
        begin
            if (a < NODES && b < NODES && a != b)
            begin
                graph[a][b] = (mode == flcf_pkg::MODE_SET);
                graph[b][a] = (mode == flcf_pkg::MODE_SET);
            end
        end
        else if (m == 0)
        begin
            r.found = 1'b0;
            r.vertex = '0;
            r.position = '0;
            r.last = 1'b1;
            pending_results.push_back(r);
        end
        else
        begin
            for (k = 0; k < m; k++)
            begin
                r.found = 1'b1;
                r.vertex = route[k];
                r.position = 5'(k);
                r.last = (k == m - 1);
                pending_results.push_back(r);
            end
        end

        // present the item after a random gap and hold it until taken
        @(negedge clk);
        while ($urandom_range(99) < send_gap)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= mode;
        s_axis_tdata <= {1'b0, len, b, a};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sent = 1'b1;
    endtask

    // stop sending and let every outstanding result come back
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_vertex_count(input logic [4:0] value);
        drain();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        vertex_limit = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [4:0] pick_vertex(input int n);
        if (n > 0 && $urandom_range(9) != 0)
            return 5'($urandom_range(n - 1, 0));
        return 5'($urandom_range(31, 0));
    endfunction

    // queries against an empty graph at the reset vertex count
    task automatic test_empty_graph();
        issue_item(flcf_pkg::MODE_PATH, 5, 5, 0, sent_flag);
        issue_item(flcf_pkg::MODE_PATH, 0, 19, 0, sent_flag);
        issue_item(flcf_pkg::MODE_CYCLE, 0, 0, 3, sent_flag);
    endtask

    // ignored edges, a triangle with a tail, then removal of one side
    task automatic test_edge_updates();
        issue_item(flcf_pkg::MODE_SET, 3, 3, 0, sent_flag);
        issue_item(flcf_pkg::MODE_SET, 0, 20, 0, sent_flag);
        issue_item(flcf_pkg::MODE_SET, 31, 2, 0, sent_flag);
        issue_item(flcf_pkg::MODE_SET, 0, 1, 0, sent_flag);
        issue_item(flcf_pkg::MODE_SET, 1, 2, 0, sent_flag);
        issue_item(flcf_pkg::MODE_SET, 2, 0, 0, sent_flag);
        issue_item(flcf_pkg::MODE_SET, 2, 19, 0, sent_flag);
        issue_item(flcf_pkg::MODE_PATH, 0, 19, 3, sent_flag);
        issue_item(flcf_pkg::MODE_CYCLE, 0, 0, 3, sent_flag);
        issue_item(flcf_pkg::MODE_PATH, 0, 19, 2, sent_flag);
        issue_item(flcf_pkg::MODE_CLEAR, 0, 2, 0, sent_flag);
        issue_item(flcf_pkg::MODE_CYCLE, 0, 0, 3, sent_flag);
        issue_item(flcf_pkg::MODE_PATH, 3, 3, 0, sent_flag);
    endtask

    // short cycles, over-long requests and a start outside the graph
    task automatic test_query_limits();
        issue_item(flcf_pkg::MODE_CYCLE, 0, 0, 0, sent_flag);
        issue_item(flcf_pkg::MODE_CYCLE, 0, 0, 1, sent_flag);
        issue_item(flcf_pkg::MODE_CYCLE, 0, 1, 2, sent_flag);
        issue_item(flcf_pkg::MODE_CYCLE, 31, 31, 31, sent_flag);
        issue_item(flcf_pkg::MODE_PATH, 0, 1, 20, sent_flag);
        issue_item(flcf_pkg::MODE_PATH, 25, 0, 1, sent_flag);
        issue_item(flcf_pkg::MODE_PATH, 19, 19, 31, sent_flag);
    endtask

    // vertex count of zero, one, all ones, then back to the full graph
    task automatic test_vertex_count();
        write_vertex_count(0);
        issue_item(flcf_pkg::MODE_PATH, 0, 0, 0, sent_flag);
        issue_item(flcf_pkg::MODE_CYCLE, 0, 0, 3, sent_flag);
        write_vertex_count(1);
        issue_item(flcf_pkg::MODE_PATH, 0, 0, 0, sent_flag);
        write_vertex_count(31);
        issue_item(flcf_pkg::MODE_PATH, 1, 19, 2, sent_flag);
        write_vertex_count(20);
    endtask

    // random edges and queries, among them chains that are then searched for
    task automatic test_random_traffic(input int gap_in, input int gap_out,
                                       input int items);
        int         issued;
        int         n;
        int         pick;
        int         span;
        int         i;
        int         j;
        logic [4:0] swap;
        logic [4:0] a;
        logic [4:0] b;
        logic [4:0] order [NODES];
        issued = 0;
        write_vertex_count(5'($urandom_range(20, 3)));
        send_gap = gap_in;
        recv_gap = gap_out;
        while (issued < items)
        begin
            if (issued >= items / 2 && issued < items / 2 + 1)
            begin
                write_vertex_count(5'($urandom_range(20, 1)));
                issued++;
            end
            n = (vertex_limit < NODES) ? int'(vertex_limit) : NODES;
            pick = $urandom_range(99);
            if (pick < 35 && n >= 2)
            begin
                // chain over shuffled vertices, then look for it
                for (i = 0; i < n; i++)
                    order[i] = 5'(i);
                for (i = n - 1; i > 0; i--)
                begin
                    j = $urandom_range(i, 0);
                    swap = order[i];
                    order[i] = order[j];
                    order[j] = swap;
                end
                span = $urandom_range(n, 2);
                for (i = 0; i + 1 < span; i++)
                begin
                    issue_item(flcf_pkg::MODE_SET, order[i], order[i + 1], 5'($urandom),
                               sent_flag);
                    issued += sent_flag;
                end
                // sometimes break the chain before the query
                if ($urandom_range(4) == 0 && span > 2)
                begin
                    i = $urandom_range(span - 2, 0);
                    issue_item(flcf_pkg::MODE_CLEAR, order[i], order[i + 1], 5'($urandom),
                               sent_flag);
                    issued += sent_flag;
                end
                issue_item(flcf_pkg::MODE_PATH, order[0], order[span - 1], 5'(span - 1),
                           sent_flag);
                issued += sent_flag;
                if (span >= 3 && $urandom_range(1) == 1)
                begin
                    issue_item(flcf_pkg::MODE_SET, order[span - 1], order[0], 5'($urandom),
                               sent_flag);
                    issued += sent_flag;
                    issue_item(flcf_pkg::MODE_CYCLE, 5'($urandom), 5'($urandom), 5'(span),
                               sent_flag);
                    issued += sent_flag;
                end
            end
            else if (pick < 70)
            begin
                // single edge set or clear between distinct vertices
                a = pick_vertex(n);
                b = pick_vertex(n);
                if (a != b)
                begin
                    issue_item((pick < 58) ? flcf_pkg::MODE_SET : flcf_pkg::MODE_CLEAR, a, b,
                               5'($urandom), sent_flag);
                    issued += sent_flag;
                end
            end
            else if (pick < 88)
            begin
                a = pick_vertex(n);
                b = pick_vertex(n);
                if ($urandom_range(9) == 0)
                    issue_item(flcf_pkg::MODE_PATH, a, b, 5'($urandom_range(31, 0)),
                               sent_flag);
                else
                    issue_item(flcf_pkg::MODE_PATH, a, b, 5'($urandom_range(n, 0)),
                               sent_flag);
                issued += sent_flag;
            end
            else
            begin
                if ($urandom_range(9) == 0)
                    issue_item(flcf_pkg::MODE_CYCLE, pick_vertex(n), pick_vertex(n),
                               5'($urandom_range(31, 0)), sent_flag);
                else
                    issue_item(flcf_pkg::MODE_CYCLE, pick_vertex(n), pick_vertex(n),
                               5'($urandom_range(n + 1, 0)), sent_flag);
                issued += sent_flag;
            end
        end
        drain();
    endtask

    initial
    begin
        for (int v = 0; v < NODES; v++)
            graph[v] = '0;
        vertex_limit = flcf_pkg::COUNT_RESET;

        // reset held from the start, released on a falling edge
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_graph();
        test_edge_updates();
        test_query_limits();
        test_vertex_count();
        test_random_traffic(24, 84, RANDOM_ITEMS);
        test_random_traffic(84, 24, RANDOM_ITEMS);
        test_random_traffic(0, 0, RANDOM_ITEMS);

        if (mismatch_count == 0)
            $display("fixed_length_path_cycle_finder_unit: match");
        else
            $display("fixed_length_path_cycle_finder_unit: mismatch");
        $finish;
    end

endmodule

[sim.f]
rtl/flcf_pkg.sv
rtl/flcf_engine.sv
rtl/fixed_length_path_cycle_finder_unit.sv
rtl/flcf_checker.sv
test/fixed_length_path_cycle_finder_unit_test.sv
